// ----- src/fss_pkg.sv -----
package fss_pkg;

	localparam int PATTERN_MAX_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int PAT_BITS        = PAT_BYTES * 8;
	localparam int CFG_W           = 64;
	localparam int LENGTH_W        = 5;
	localparam int FIELD_W         = 16;

	localparam logic [1:0] ACT_DATA       = 2'd0;
	localparam logic [1:0] ACT_FIELD_END  = 2'd1;
	localparam logic [1:0] ACT_RECORD_END = 2'd2;

	localparam logic [1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [1:0] REG_LENGTH   = 2'd2;

	localparam logic RCNORMAL = 1'b1;

	// per-item control from the stage register to the window
	typedef struct packed {
		logic       shift;
		logic       clear;
		logic [7:0] data;
	} fss_step_t;

endpackage

// ----- src/fss_in_if.sv -----
interface fss_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic       record_ok;

	modport source (output valid, output action, output data_byte, output record_ok,
		input ready);
	modport sink (input valid, input action, input data_byte, input record_ok,
		output ready);
endinterface

// ----- src/fss_out_if.sv -----
interface fss_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [15:0] field_index;

	modport source (output valid, output found, output field_index, input ready);
	modport sink (input valid, input found, input field_index, output ready);
endinterface

// ----- src/fss_cfg.sv -----
module fss_cfg
	import fss_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [CFG_W-1:0]    wr_data,
	output logic [PAT_BITS-1:0] pattern,
	output logic [LENGTH_W-1:0] pattern_length
);

	logic [CFG_W-1:0]    pat_low_q;
	logic [CFG_W-1:0]    pat_high_q;
	logic [LENGTH_W-1:0] length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			length_q   <= LENGTH_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_PAT_LOW:  pat_low_q  <= wr_data;
				REG_PAT_HIGH: pat_high_q <= wr_data;
				REG_LENGTH:   length_q   <= wr_data[LENGTH_W-1:0];
				default:      ;
			endcase
		end
	end

	assign pattern        = {pat_high_q, pat_low_q};
	assign pattern_length = length_q;

endmodule

// ----- src/fss_match.sv -----
module fss_match
	import fss_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fss_step_t           step,
	input  logic [PAT_BITS-1:0] pattern,
	input  logic [LENGTH_W-1:0] pattern_length,
	output logic                hit
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [7:0]       win_q  [PATTERN_MAX];
	logic [7:0]       win_nx [PATTERN_MAX];
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] cnt_nx;
	logic [LEN_W-1:0] eff_len;
	logic             all_eq;

	// zero means one byte, above the window depth saturates
	always_comb begin
		if (pattern_length == '0) begin
			eff_len = LEN_W'(1);
		end else if (pattern_length > LENGTH_W'(PATTERN_MAX)) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end else begin
			eff_len = pattern_length[LEN_W-1:0];
		end
	end

	always_comb begin
		win_nx[0] = step.data;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	assign cnt_nx = (cnt_q == LEN_W'(PATTERN_MAX)) ? cnt_q : cnt_q + LEN_W'(1);

	// pattern byte i lines up with window entry eff_len-1-i (entry 0 is newest)
	always_comb begin
		logic [LEN_W-1:0] d;
		all_eq = (cnt_nx >= eff_len);
		for (int i = 0; i < PATTERN_MAX; i++) begin
			d = eff_len - LEN_W'(i) - LEN_W'(1);
			if (LEN_W'(i) < eff_len) begin
				if (pattern[i*8 +: 8] != win_nx[d[IDX_W-1:0]]) begin
					all_eq = 1'b0;
				end
			end
		end
	end

	assign hit = step.shift && all_eq;

	// entries past the byte count are never compared, so no reset here
	always_ff @(posedge clk) begin
		if (step.shift) begin
			win_q <= win_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (step.clear) begin
			cnt_q <= '0;
		end else if (step.shift) begin
			cnt_q <= cnt_nx;
		end
	end

endmodule

// ----- src/field_substring_search_top.sv -----
// A record-end item is taken into the stage register, then sets the result register.
// Throughput: one item per cycle; stream.ready drops only while the stage
// register holds a record end and the result register is full and not taken.
// Window compare is combinational from the stage register into the registered match state.
// Reset (arst_n low, asynchronous): pattern zero, length one, counters and
// match state cleared, no item in flight, no result pending.
module field_substring_search_top
	import fss_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	fss_in_if.sink           stream,
	fss_out_if.source        result,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	logic [PAT_BITS-1:0] pattern;
	logic [LENGTH_W-1:0] pattern_length;

	logic               valid_s1;
	logic [1:0]         action_s1;
	logic [7:0]         data_s1;
	logic               ok_s1;
	logic               adv_s1;
	logic               take;
	fss_step_t          step;
	logic               hit;

	logic               match_seen_q;
	logic [FIELD_W-1:0] cur_field_q;
	logic [FIELD_W-1:0] match_field_q;

	logic               res_valid_q;
	logic               res_found_q;
	logic [FIELD_W-1:0] res_index_q;
	logic               found_nx;

	fss_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.pattern        (pattern),
		.pattern_length (pattern_length)
	);

	// only a record end needs room in the result register
	assign adv_s1 = valid_s1 &&
		(action_s1 != ACT_RECORD_END || !res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || adv_s1;
	assign take = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1 <= stream.action;
			data_s1   <= stream.data_byte;
			ok_s1     <= stream.record_ok;
		end
	end

	assign step.shift = adv_s1 && (action_s1 == ACT_DATA);
	assign step.clear = adv_s1 &&
		(action_s1 == ACT_FIELD_END || action_s1 == ACT_RECORD_END);
	assign step.data  = data_s1;

	fss_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.pattern        (pattern),
		.pattern_length (pattern_length),
		.hit            (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q  <= 1'b0;
			cur_field_q   <= '0;
			match_field_q <= '0;
		end else if (adv_s1) begin
			case (action_s1)
				ACT_DATA: begin
					if (hit && !match_seen_q) begin
						match_seen_q  <= 1'b1;
						match_field_q <= cur_field_q;
					end
				end
				ACT_FIELD_END: begin
					cur_field_q <= cur_field_q + FIELD_W'(1);
				end
				ACT_RECORD_END: begin
					match_seen_q  <= 1'b0;
					cur_field_q   <= '0;
					match_field_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign found_nx = match_seen_q && (ok_s1 == RCNORMAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && action_s1 == ACT_RECORD_END) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && action_s1 == ACT_RECORD_END) begin
			res_found_q <= found_nx;
			res_index_q <= found_nx ? match_field_q : '0;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.found       = res_found_q;
	assign result.field_index = res_index_q;

	a_index_zero_when_absent: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.found |-> result.field_index == '0)
		else $error("field_index nonzero without a match");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && action_s1 == ACT_RECORD_END && res_valid_q && !result.ready
		|-> !stream.ready)
		else $error("record end would overwrite a pending result");

	a_match_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_seen_q) |-> $past(adv_s1 && action_s1 == ACT_DATA && hit))
		else $error("match flag set without a data hit");

	a_field_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_field_q) |-> $past(adv_s1 &&
			(action_s1 == ACT_FIELD_END || action_s1 == ACT_RECORD_END)))
		else $error("field counter changed without a field or record end");

endmodule

// ----- bench/field_substring_search_top_test.sv -----
`timescale 1ns / 1ps

module field_substring_search_top_test;
	import fss_pkg::*;

	localparam logic [1:0] ACT_UNUSED  = 2'd3;
	localparam logic [1:0] REG_SPARE   = 2'd3;
	localparam int         QUIET_LIMIT = 2000;

	typedef struct packed {
		logic               found;
		logic [FIELD_W-1:0] field_idx;
	} search_result_t;

	// Tracks the search state of the block and holds the results it owes.
	class record_search_checker;
		logic [7:0]          window [PAT_BYTES];
		int                  bytes_seen;
		bit                  hit_seen;
		logic [FIELD_W-1:0]  field_now;
		logic [FIELD_W-1:0]  hit_field;
		logic [CFG_W-1:0]    pat_low;
		logic [CFG_W-1:0]    pat_high;
		logic [LENGTH_W-1:0] pat_len;
		search_result_t      pending_results [$];
		int                  mismatches;
		int                  results_checked;
		int                  hits_reported;

		function void clear_window();
			foreach (window[i]) window[i] = 8'h00;
			bytes_seen = 0;
		endfunction

		function void reset_all();
			pat_low = '0;
			pat_high = '0;
			pat_len = LENGTH_W'(1);
			clear_window();
			hit_seen = 0;
			field_now = '0;
			hit_field = '0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_PAT_LOW: pat_low = data;
				REG_PAT_HIGH: pat_high = data;
				REG_LENGTH: pat_len = data[LENGTH_W-1:0];
				default: ;
			endcase
		endfunction

		function int active_length();
			if (pat_len == 0)
				return 1;
			if (pat_len > PATTERN_MAX_DEF)
				return PATTERN_MAX_DEF;
			return int'(pat_len);
		endfunction

		function logic [7:0] pattern_byte(int j);
			logic [PAT_BITS-1:0] pat;
			pat = {pat_high, pat_low};
			return pat[8*j +: 8];
		endfunction

		function void take_item(logic [1:0] act, logic [7:0] data, logic ok);
			int len;
			bit hit;
			case (act)
				ACT_DATA: begin
					for (int i = PAT_BYTES - 1; i > 0; i--)
						window[i] = window[i-1];
					window[0] = data;
					if (bytes_seen < PATTERN_MAX_DEF)
						bytes_seen++;
					len = active_length();
					hit = (bytes_seen >= len);
					for (int i = 0; i < len; i++)
						if (pattern_byte(i) != window[len-1-i])
							hit = 0;
					if (hit && !hit_seen) begin
						hit_seen = 1;
						hit_field = field_now;
					end
				end
				ACT_FIELD_END: begin
					clear_window();
					field_now++;
				end
				ACT_RECORD_END: begin
					if (hit_seen && ok == RCNORMAL)
						pending_results.push_back('{found: 1'b1, field_idx: hit_field});
					else
						pending_results.push_back('{found: 1'b0, field_idx: '0});
					clear_window();
					hit_seen = 0;
					field_now = '0;
					hit_field = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic found, logic [FIELD_W-1:0] field_idx);
			search_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none pending: found=%0b field=%0d",
						$realtime, found, field_idx);
				return;
			end
			want = pending_results.pop_front();
			results_checked++;
			if (want.found)
				hits_reported++;
			if (found !== want.found || field_idx !== want.field_idx) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected found=%0b field=%0d, got found=%0b field=%0d",
						$realtime, want.found, want.field_idx, found, field_idx);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             wr_en = 1'b0;
	logic [1:0]       wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;

	fss_in_if  stream_if();
	fss_out_if result_if();

	record_search_checker tracker;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int settings_used = 0;

	field_substring_search_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream_if),
		.result   (result_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #1 clk = ~clk;

	initial begin
		stream_if.valid = 1'b0;
		stream_if.action = ACT_DATA;
		stream_if.data_byte = '0;
		stream_if.record_ok = 1'b0;
		result_if.ready = 1'b0;
	end

	always @(posedge clk) begin
		result_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			tracker.check_result(result_if.found, result_if.field_index);
		if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, tracker.pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_item(logic [1:0] act, logic [7:0] data, logic ok);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			stream_if.valid <= 1'b0;
			@(posedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.action <= act;
		stream_if.data_byte <= data;
		stream_if.record_ok <= ok;
		@(posedge clk);
		while (!stream_if.ready)
			@(posedge clk);
		tracker.take_item(act, data, ok);
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	// Drain all results with valid held low, then let the pipeline settle.
	task automatic wait_idle();
		stream_if.valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	task automatic load_pattern(logic [CFG_W-1:0] low, logic [CFG_W-1:0] high,
			logic [LENGTH_W-1:0] len);
		logic [CFG_W-1:0] len_word;
		len_word = {$urandom, $urandom};
		len_word[LENGTH_W-1:0] = len;
		put_reg(REG_PAT_LOW, low);
		put_reg(REG_PAT_HIGH, high);
		put_reg(REG_LENGTH, len_word);
		put_reg(REG_SPARE, {$urandom, $urandom});
		wr_en <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(99) < 30)
			return 8'($urandom_range(255));
		return tracker.pattern_byte($urandom_range(tracker.active_length() - 1));
	endfunction

	// Well-formed record with random content; plants full, corrupted and split patterns.
	task automatic send_record();
		int n_fields;
		int n_bytes;
		int len;
		int cut;
		logic [7:0] carry [$];
		n_fields = $urandom_range(1, 4);
		len = tracker.active_length();
		for (int f = 0; f < n_fields; f++) begin
			while (carry.size() != 0)
				send_item(ACT_DATA, carry.pop_front(), 1'($urandom));
			n_bytes = $urandom_range(0, 6);
			for (int b = 0; b < n_bytes; b++) begin
				if ($urandom_range(19) == 0)
					send_item(ACT_UNUSED, 8'($urandom), 1'($urandom));
				send_item(ACT_DATA, pick_byte(), 1'($urandom));
			end
			case ($urandom_range(3))
				0: begin
					for (int j = 0; j < len; j++)
						send_item(ACT_DATA, tracker.pattern_byte(j), 1'($urandom));
				end
				1: begin
					cut = $urandom_range(len - 1);
					for (int j = 0; j < len; j++)
						send_item(ACT_DATA,
							tracker.pattern_byte(j) ^ ((j == cut) ? 8'($urandom_range(1, 255)) : 8'h00),
							1'($urandom));
				end
				2: begin
					// pattern straddles a field end and must not match
					if (len > 1 && f < n_fields - 1) begin
						cut = $urandom_range(1, len - 1);
						for (int j = 0; j < len; j++)
							if (j < cut)
								send_item(ACT_DATA, tracker.pattern_byte(j), 1'($urandom));
							else
								carry.push_back(tracker.pattern_byte(j));
					end
				end
				default: ;
			endcase
			if (f < n_fields - 1 || $urandom_range(3) == 0)
				send_item(ACT_FIELD_END, 8'($urandom), 1'($urandom));
		end
		send_item(ACT_RECORD_END, 8'($urandom), $urandom_range(4) != 0);
	endtask

	initial begin
		logic [CFG_W-1:0]    low;
		logic [CFG_W-1:0]    high;
		logic [LENGTH_W-1:0] len;
		logic [7:0]          b0;
		logic [7:0]          b1;
		int                  seg_start;
		int                  seg_records;

		tracker = new;
		tracker.reset_all();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern is a single zero byte; the unused action must be ignored
		send_item(ACT_DATA, 8'hFF, 1'b1);
		send_item(ACT_UNUSED, 8'h00, 1'b1);
		send_item(ACT_FIELD_END, 8'h00, 1'b0);
		send_item(ACT_DATA, 8'h00, 1'b0);
		send_item(ACT_RECORD_END, 8'hFF, 1'b1);
		// abnormal record hides its match
		send_item(ACT_DATA, 8'h00, 1'b1);
		send_item(ACT_RECORD_END, 8'h00, 1'b0);
		wait_idle();

		// zero length acts as one; the first matching field is kept
		load_pattern(64'hA5, {$urandom, $urandom}, '0);
		send_item(ACT_DATA, 8'hA5, 1'b0);
		send_item(ACT_DATA, 8'hA5, 1'b0);
		send_item(ACT_FIELD_END, 8'hA5, 1'b1);
		send_item(ACT_DATA, 8'hA5, 1'b0);
		send_item(ACT_RECORD_END, 8'h00, 1'b1);
		wait_idle();

		// oversized length saturates to the full window
		load_pattern('1, '1, '1);
		repeat (16) send_item(ACT_DATA, 8'hFF, 1'b0);
		send_item(ACT_RECORD_END, 8'hFF, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 53; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 53; end
				default: begin send_idle_pct = 20; stall_pct = 20; end
			endcase
			for (int s = 0; s < 2; s++) begin
				wait_idle();
				low = {$urandom, $urandom};
				high = {$urandom, $urandom};
				b0 = 8'($urandom);
				b1 = 8'($urandom);
				case (ph * 2 + s)
					0: len = LENGTH_W'(1);
					1: len = LENGTH_W'(16);
					2: len = LENGTH_W'($urandom_range(17, 31));
					3: len = '0;
					4: len = LENGTH_W'($urandom_range(2, 15));
					5: begin
						// repeated byte: overlapping occurrences
						low = {8{b0}};
						high = {8{b0}};
						len = LENGTH_W'(8);
					end
					6: begin
						low = {4{b1, b0}};
						high = {4{b1, b0}};
						len = LENGTH_W'(9);
					end
					default: len = LENGTH_W'($urandom_range(1, 16));
				endcase
				load_pattern(low, high, len);
				seg_start = items_sent;
				seg_records = 0;
				while (items_sent - seg_start < 60 || seg_records < 2) begin
					send_record();
					seg_records++;
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("run covered %0d items over %0d pattern settings and four handshake phases",
			items_sent, settings_used);
		$display("%0d records checked, %0d of them with a match", tracker.results_checked,
			tracker.hits_reported);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
